/* rtl/ffk_pkg.sv */
// ----------------------------------------------------------------------------
// ffk_pkg
// shared constants and helpers for the finger forward kinematics block
// ----------------------------------------------------------------------------
package ffk_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int OUT_W           = 19;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALM_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_3      = 3'd5;

  localparam logic [31:0] GAIN_Q31 = 32'h4DBA76D4;

  // arctangent of 2^-i, 2^31 = pi
  function automatic logic [31:0] atan_q31(input int i);
    logic [31:0] t;
    begin
      case (i)
        0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
        3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
        9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
        15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
        21: t = 32'h00000146; 22: t = 32'h000000A3; default: t = 32'h00000051;
      endcase
      return t;
    end
  endfunction

  typedef struct packed {
    logic side;
    logic [15:0] joint_angle_0;
    logic [15:0] joint_angle_1;
    logic [15:0] joint_angle_2;
    logic [15:0] joint_angle_3;
  } ffk_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] tip_x;
    logic [OUT_W-1:0] tip_y;
    logic [OUT_W-1:0] tip_z;
  } ffk_out_t;

endpackage

/* rtl/ffk_if.sv */
// ----------------------------------------------------------------------------
// ffk_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface ffk_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ffk_cordic.sv */
// ----------------------------------------------------------------------------
// ffk_cordic
// pipelined sine/cosine, one cordic iteration per stage, stall by enable
// ----------------------------------------------------------------------------
module ffk_cordic import ffk_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int DW = ANGLE_BITS + 2
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [15:0]          angle,
  output logic signed [DW-1:0] sin_o,
  output logic signed [DW-1:0] cos_o
);
  localparam int T = ANGLE_BITS - 2;
  localparam int NS = T + 1;
  localparam int AW = ANGLE_BITS + 1;

  logic signed [DW-1:0] x_r [NS];
  logic signed [DW-1:0] y_r [NS];
  logic signed [AW-1:0] z_r [NS];
  logic                 f_r [NS];

  logic signed [AW-1:0] a_ext;
  logic signed [AW-1:0] a_fold;
  logic                 flip;
  localparam logic [31:0] X0 =
    (GAIN_Q31 + (32'd1 << (30 - T))) >> (31 - T);

  always_comb begin
    if (ANGLE_BITS >= 16)
      a_ext = AW'(signed'(angle)) <<< (ANGLE_BITS >= 16 ? ANGLE_BITS - 16 : 0);
    else
      a_ext = AW'(signed'(angle) >>> (ANGLE_BITS < 16 ? 16 - ANGLE_BITS : 0));
    flip = 1'b0;
    a_fold = a_ext;
    if (a_ext >= (AW'(1) <<< (ANGLE_BITS - 2))) begin
      a_fold = a_ext - (AW'(1) <<< (ANGLE_BITS - 1));
      flip = 1'b1;
    end else if (a_ext < -(AW'(1) <<< (ANGLE_BITS - 2))) begin
      a_fold = a_ext + (AW'(1) <<< (ANGLE_BITS - 1));
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= DW'(X0);
      y_r[0] <= '0;
      z_r[0] <= a_fold;
      f_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < T; i++) begin : g_it
    localparam logic [31:0] DA = atan_q31(i) >> (32 - ANGLE_BITS);
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][AW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - AW'(DA);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + AW'(DA);
        end
      end
    end
  end

  assign cos_o = f_r[T] ? -x_r[T] : x_r[T];
  assign sin_o = f_r[T] ? -y_r[T] : y_r[T];
endmodule

/* rtl/finger_forward_kinematics.sv */
// ----------------------------------------------------------------------------
// finger_forward_kinematics
// fingertip position of a four-joint finger from side flag and joint angles
// ----------------------------------------------------------------------------
// Fully pipelined: one pose transaction is accepted every cycle that the pipe
// is not stalled. The path runs through the cordic stages (one per iteration
// plus the input stage), then seven stages of rotate-and-round multiplies
// and offsets, then the final round/saturate into the output register.
// The whole pipe advances only when the output register is free or being
// drained, so a stall holds every item in place. Configuration registers are
// expected to stay put while transactions are in flight.
module finger_forward_kinematics import ffk_pkg::*; #(
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ffk_if.sink                   in_ch,
  ffk_if.source                 out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int T  = ANGLE_BITS - 2;
  localparam int G  = LENGTH_BITS - 12;
  localparam int DW = ANGLE_BITS + 2;   // trig width
  localparam int LW = 23 + G;           // length intermediate width
  localparam int PW = LW + DW;          // product width
  localparam int CL = ANGLE_BITS - 1;   // cordic latency
  localparam int NS = CL + 7;           // pipe depth ahead of the output register

  // configuration registers
  logic signed [15:0] base_r, palm_r;
  logic [14:0]        l0_r, l1_r, l2_r, l3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0; palm_r <= '0;
      l0_r <= '0; l1_r <= '0; l2_r <= '0; l3_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BASE_OFFSET: base_r <= cfg_data;
        REG_PALM_OFFSET: palm_r <= cfg_data;
        REG_LINK_0:      l0_r   <= cfg_data[14:0];
        REG_LINK_1:      l1_r   <= cfg_data[14:0];
        REG_LINK_2:      l2_r   <= cfg_data[14:0];
        REG_LINK_3:      l3_r   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // lengths scaled to G fraction bits
  logic signed [LW-1:0] l0s, l1s, l2s, l3s, lbs_p, lps;
  assign l0s   = LW'($signed({1'b0, l0_r})) <<< G;
  assign l1s   = LW'($signed({1'b0, l1_r})) <<< G;
  assign l2s   = LW'($signed({1'b0, l2_r})) <<< G;
  assign l3s   = LW'($signed({1'b0, l3_r})) <<< G;
  assign lbs_p = LW'(base_r) <<< G;
  assign lps   = LW'(palm_r) <<< G;

  function automatic logic signed [LW-1:0] mulr(input logic signed [LW-1:0] v,
                                                input logic signed [DW-1:0] t);
    logic signed [PW-1:0] p;
    begin
      p = PW'(v) * PW'(t) + (PW'(1) <<< (T - 1));
      return LW'(p >>> T);
    end
  endfunction

  // pipe control: global enable, valid shift line
  logic en, out_valid_r;
  logic [NS-1:0] vld_r;
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_ch.valid};
      out_valid_r <= vld_r[NS-1];
    end
  end
  assign out_ch.valid = out_valid_r;

  ffk_in_t pin;
  assign pin = ffk_in_t'(in_ch.data);

  // four cordic pipes in parallel
  logic signed [DW-1:0] s0, c0, s1, c1, s2, c2, s3, c3;
  ffk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cor0 (.clk, .en, .angle(pin.joint_angle_0),
    .sin_o(s0), .cos_o(c0));
  ffk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cor1 (.clk, .en, .angle(pin.joint_angle_1),
    .sin_o(s1), .cos_o(c1));
  ffk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cor2 (.clk, .en, .angle(pin.joint_angle_2),
    .sin_o(s2), .cos_o(c2));
  ffk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cor3 (.clk, .en, .angle(pin.joint_angle_3),
    .sin_o(s3), .cos_o(c3));

  // side flag rides along with the cordic
  logic side_d_r [CL];
  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r[0] <= pin.side;
      for (int k = 1; k < CL; k++) side_d_r[k] <= side_d_r[k-1];
    end
  end

  // post stage registers: trig delayed to where they are used
  logic signed [DW-1:0] s0_r [5], c0_r [5], s1_r [3], c1_r [3], s2_r [1], c2_r [1];
  logic side_r [6];
  logic signed [LW-1:0] a_r, b_r, pxa_r, pxb_r, px_r, pya_r, pyb_r, py_r;
  logic signed [LW-1:0] ra_r, rb_r, r_r, ha_r, hb_r, h_r, xa_r, ya_r, x_r, y_r;
  logic signed [LW-1:0] h2_r, h3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: tip link through joint 3
      a_r <= l2s + mulr(l3s, c3);
      b_r <= mulr(l3s, s3);
      s2_r[0] <= s2; c2_r[0] <= c2;
      s1_r[0] <= s1; c1_r[0] <= c1;
      s0_r[0] <= s0; c0_r[0] <= c0;
      side_r[0] <= side_d_r[CL-1];
      for (int k = 1; k < 6; k++) side_r[k] <= side_r[k-1];
      for (int k = 1; k < 5; k++) begin
        s0_r[k] <= s0_r[k-1]; c0_r[k] <= c0_r[k-1];
      end
      for (int k = 1; k < 3; k++) begin
        s1_r[k] <= s1_r[k-1]; c1_r[k] <= c1_r[k-1];
      end
      // stage 2/3: joint 2 rotation
      pxa_r <= mulr(a_r, c2_r[0]);
      pxb_r <= mulr(b_r, s2_r[0]);
      pya_r <= mulr(a_r, s2_r[0]);
      pyb_r <= mulr(b_r, c2_r[0]);
      px_r  <= l1s + pxa_r - pxb_r;
      py_r  <= pya_r + pyb_r;
      // stage 4/5: joint 1 rotation
      ra_r <= mulr(px_r, c1_r[2]);
      rb_r <= mulr(py_r, s1_r[2]);
      ha_r <= mulr(px_r, s1_r[2]);
      hb_r <= mulr(py_r, c1_r[2]);
      r_r  <= l0s + ra_r - rb_r;
      h_r  <= ha_r + hb_r;
      // stage 6/7: base rotation and offsets
      xa_r <= mulr(r_r, s0_r[4]);
      ya_r <= mulr(r_r, c0_r[4]);
      h2_r <= h_r;
      x_r  <= -xa_r - (side_r[5] ? lbs_p : -lbs_p);
      y_r  <= ya_r + lps;
      h3_r <= h2_r;
    end
  end

  function automatic logic [OUT_W-1:0] finish(input logic signed [LW-1:0] v);
    logic signed [LW:0] r;
    begin
      if (G > 0) r = (($signed({v[LW-1], v}) + ((LW+1)'(1) <<< (G > 0 ? G - 1 : 0)))
                      >>> G);
      else r = $signed({v[LW-1], v});
      if (r > (LW+1)'(262143)) return OUT_W'(262143);
      if (r < -(LW+1)'(262144)) return OUT_W'(-262144);
      return OUT_W'(r);
    end
  endfunction

  ffk_out_t res_r;
  always_ff @(posedge clk) begin
    if (en) begin
      res_r.tip_x <= finish(x_r);
      res_r.tip_y <= finish(y_r);
      res_r.tip_z <= finish(h3_r);
    end
  end
  assign out_ch.data = res_r;
endmodule
